### hw/rtl/brb_pkg.sv
// shared constants, codes, types and helpers for the broadcast ring buffer
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

    localparam int SLOT_COUNT    = 16;
    localparam int CLIENT_COUNT  = 8;
    localparam int MESSAGE_WIDTH = 32;

    localparam int POS_W     = 16;
    localparam int CLIENT_W  = 3;
    localparam int SLOT_W    = $clog2(SLOT_COUNT);
    localparam int CIDX_W    = (CLIENT_COUNT > 1) ? $clog2(CLIENT_COUNT) : 1;
    localparam int CNT_W     = $clog2(CLIENT_COUNT + 1);
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CIDX_W-1:0] cidx_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE  = 2'd0,
        MODE_READ   = 2'd1,
        MODE_ADD    = 2'd2,
        MODE_REMOVE = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BUSY    = 2'd1,
        ST_NACK    = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic finish;
        logic drain_step;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_drain;
        logic drain_done;
        logic out_free;
    } dp_stat_t;

    function automatic cidx_t client_idx(input logic [CLIENT_W-1:0] id);
        return CIDX_W'(id);
    endfunction

    // slot index of pos + 1, given the slot index of pos
    function automatic slot_t slot_inc(input slot_t slot, input pos_t pos);
        slot_t res;
        if (pos == {POS_W{1'b1}})
            res = '0;
        else if (slot == SLOT_W'(SLOT_COUNT - 1))
            res = '0;
        else
            res = slot + SLOT_W'(1);
        return res;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/brb_req_if.sv
// request channel: valid/ready with one request item
`timescale 1ns / 1ps
`default_nettype none

interface brb_req_if;
    import brb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [CLIENT_W-1:0]      client_id;
    logic [MESSAGE_WIDTH-1:0] message_in;

    modport source (output valid, output mode, output client_id, output message_in,
                    input ready);
    modport sink (input valid, input mode, input client_id, input message_in,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/brb_rsp_if.sv
// response channel: valid/ready with one result item
`timescale 1ns / 1ps
`default_nettype none

interface brb_rsp_if;
    import brb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [MESSAGE_WIDTH-1:0] message_out;
    logic [POS_W-1:0]         start_position;

    modport source (output valid, output status, output message_out, output start_position,
                    input ready);
    modport sink (input valid, input status, input message_out, input start_position,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/brb_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module brb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/brb_datapath.sv
// ring buffer state, request decode, slot updates and output register
`timescale 1ns / 1ps
`default_nettype none

module brb_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire brb_pkg::dp_cmd_t                  cmd,
    output brb_pkg::dp_stat_t                      stat,
    input  wire logic [brb_pkg::MODE_W-1:0]        req_mode,
    input  wire logic [brb_pkg::CLIENT_W-1:0]      req_client_id,
    input  wire logic [brb_pkg::MESSAGE_WIDTH-1:0] req_message_in,
    input  wire logic                              rsp_ready,
    output logic                                   rsp_valid,
    output logic      [brb_pkg::STATUS_W-1:0]      rsp_status,
    output logic      [brb_pkg::MESSAGE_WIDTH-1:0] rsp_message_out,
    output logic      [brb_pkg::POS_W-1:0]         rsp_start_position
);
    import brb_pkg::*;

    // captured request
    mode_t                    mode_reg;
    logic [CLIENT_W-1:0]      client_reg;
    logic [MESSAGE_WIDTH-1:0] msg_reg;

    // buffer state
    pos_t  wpos_reg;
    slot_t wslot_reg;
    cnt_t  active_cnt_reg;
    cnt_t  pend_reg   [SLOT_COUNT];
    logic  active_reg [CLIENT_COUNT];
    pos_t  rpos_reg   [CLIENT_COUNT];
    slot_t rslot_reg  [CLIENT_COUNT];

    // output register
    logic                     out_valid_reg;
    status_t                  out_status_reg;
    logic [MESSAGE_WIDTH-1:0] out_msg_reg;
    pos_t                     out_start_reg;

    logic [MESSAGE_WIDTH-1:0] ram_rdata;

    cidx_t   cidx;
    logic    in_range;
    logic    active;
    pos_t    rpos;
    slot_t   rslot;
    pos_t    lag;
    logic    lag_bad;
    slot_t   paddr;
    cnt_t    pend;
    status_t res_status;
    logic    res_ok;

    assign cidx     = client_idx(client_reg);
    assign in_range = 32'(client_reg) < 32'(CLIENT_COUNT);
    assign active   = active_reg[cidx];
    assign rpos     = rpos_reg[cidx];
    assign rslot    = rslot_reg[cidx];
    assign lag      = wpos_reg - rpos;
    assign lag_bad  = (lag == '0) || (lag > POS_W'(SLOT_COUNT));
    assign paddr    = (mode_reg == MODE_WRITE) ? wslot_reg : rslot;
    assign pend     = pend_reg[paddr];

    always_comb
    begin
        res_status = ST_OK;
        if (mode_reg == MODE_WRITE)
        begin
            if (pend != '0)
                res_status = ST_BUSY;
        end
        else if (!in_range)
        begin
            res_status = ST_INVALID;
        end
        else if (mode_reg == MODE_ADD)
        begin
            if (active)
                res_status = ST_INVALID;
        end
        else if (!active)
        begin
            res_status = ST_INVALID;
        end
        else if (mode_reg == MODE_READ)
        begin
            if (lag_bad || pend == '0)
                res_status = ST_NACK;
        end
    end

    assign res_ok = (res_status == ST_OK);

    assign stat.need_drain = (mode_reg == MODE_REMOVE) && in_range && active;
    assign stat.drain_done = lag_bad;
    assign stat.out_free   = !out_valid_reg || rsp_ready;

    // message store: read at the requesting client's slot while the item is taken
    brb_ram #(
        .WIDTH (MESSAGE_WIDTH),
        .DEPTH (SLOT_COUNT)
    ) u_msg_ram (
        .clk     (clk),
        .wr_en   (cmd.finish && mode_reg == MODE_WRITE && res_ok),
        .wr_addr (wslot_reg),
        .wr_data (msg_reg),
        .rd_en   (cmd.accept),
        .rd_addr (rslot_reg[client_idx(req_client_id)]),
        .rd_data (ram_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg       <= '0;
            wslot_reg      <= '0;
            active_cnt_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                pend_reg[i] <= '0;
            end
            for (int i = 0; i < CLIENT_COUNT; i++)
            begin
                active_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;

            if (cmd.drain_step)
            begin
                if (pend != '0)
                    pend_reg[paddr] <= pend - CNT_W'(1);
            end
            else if (cmd.finish && res_ok)
            begin
                case (mode_reg)
                    MODE_WRITE:
                    begin
                        pend_reg[wslot_reg] <= active_cnt_reg;
                        wpos_reg            <= wpos_reg + POS_W'(1);
                        wslot_reg           <= slot_inc(wslot_reg, wpos_reg);
                    end
                    MODE_READ:
                    begin
                        pend_reg[paddr] <= pend - CNT_W'(1);
                    end
                    MODE_ADD:
                    begin
                        active_reg[cidx] <= 1'b1;
                        active_cnt_reg   <= active_cnt_reg + CNT_W'(1);
                    end
                    default:
                    begin
                        active_reg[cidx] <= 1'b0;
                        if (active_cnt_reg != '0)
                            active_cnt_reg <= active_cnt_reg - CNT_W'(1);
                    end
                endcase
            end
        end
    end

    // payload state
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg   <= mode_t'(req_mode);
            client_reg <= req_client_id;
            msg_reg    <= req_message_in;
        end

        if (cmd.drain_step)
        begin
            rpos_reg[cidx]  <= rpos + POS_W'(1);
            rslot_reg[cidx] <= slot_inc(rslot, rpos);
        end
        else if (cmd.finish && res_ok)
        begin
            if (mode_reg == MODE_READ)
            begin
                rpos_reg[cidx]  <= rpos + POS_W'(1);
                rslot_reg[cidx] <= slot_inc(rslot, rpos);
            end
            else if (mode_reg == MODE_ADD)
            begin
                rpos_reg[cidx]  <= wpos_reg;
                rslot_reg[cidx] <= wslot_reg;
            end
        end

        if (cmd.finish)
        begin
            out_status_reg <= res_status;
            out_msg_reg    <= (mode_reg == MODE_READ && res_ok) ? ram_rdata : '0;
            out_start_reg  <= (mode_reg == MODE_ADD && res_ok) ? wpos_reg : '0;
        end
    end

    assign rsp_valid          = out_valid_reg;
    assign rsp_status         = out_status_reg;
    assign rsp_message_out    = out_msg_reg;
    assign rsp_start_position = out_start_reg;

endmodule

`default_nettype wire

### hw/rtl/brb_ctrl.sv
// sequencing state machine: take item, execute, drain on reader removal
`timescale 1ns / 1ps
`default_nettype none

module brb_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire brb_pkg::dp_stat_t stat,
    output brb_pkg::dp_cmd_t       cmd
);
    import brb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.accept     = ready_reg && req_valid;
        state_next     = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.need_drain)
                    state_next = S_DRAIN;
                else if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DRAIN:
            begin
                // one unread slot released per cycle
                if (!stat.drain_done)
                    cmd.drain_step = 1'b1;
                else if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign req_ready = ready_reg;

endmodule

`default_nettype wire

### hw/rtl/broadcast_ring_buffer_refcount_core.sv
// top level of the broadcast ring buffer with per-slot reader counts
// write, read and add each pass a take step and an execute step; execute waits until the output register is free
// remove adds a drain step for each unread slot of the client (at most SLOT_COUNT), one per cycle
// result is valid the cycle after the final step and waits in an output register
// reset clears write position, pending counts, active readers and the state machine
// message words and reader positions are undefined until written
`timescale 1ns / 1ps
`default_nettype none

module broadcast_ring_buffer_refcount_core (
    input wire logic clk,
    input wire logic rst_n,
    brb_req_if.sink  req,
    brb_rsp_if.source rsp
);
    import brb_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    brb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    brb_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .req_mode           (req.mode),
        .req_client_id      (req.client_id),
        .req_message_in     (req.message_in),
        .rsp_ready          (rsp.ready),
        .rsp_valid          (rsp.valid),
        .rsp_status         (rsp.status),
        .rsp_message_out    (rsp.message_out),
        .rsp_start_position (rsp.start_position)
    );

endmodule

`default_nettype wire
